// ===== sv/pdq_pkg.sv =====
// Package for the per-destination packet queues: sizes, codes, queue beat type.
// Used by every module of the block but pdq_ram; depends on nothing.
package pdq_pkg;
   localparam int NUM_QUEUES        = 8;
   localparam int ENTRIES_PER_QUEUE = 8;
   localparam int SLOT_W   = $clog2(NUM_QUEUES);
   localparam int POS_W    = (ENTRIES_PER_QUEUE > 1) ? $clog2(ENTRIES_PER_QUEUE) : 1;
   localparam int CNT_W    = $clog2(ENTRIES_PER_QUEUE + 1);
   localparam int RANK_W   = 3;
   localparam int DEPTH    = NUM_QUEUES * ENTRIES_PER_QUEUE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int WORD_W   = 24;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_PACKET  = 2'd1;
   localparam logic [1:0] KIND_NOTHING = 2'd2;

   localparam logic [1:0] ST_QUEUED   = 2'd0;
   localparam logic [1:0] ST_REPLACED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOSLOT   = 2'd3;

   // one accepted request as it waits for the back end
   typedef struct packed {
      logic        func;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [15:0] handle;
      logic [7:0]  handler;
   } cmd_type;
endpackage

// ===== sv/pdq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== sv/pdq_front.sv =====
// Front end: accepts request beats, maps external packets to address 0 and
// holds them in a two-entry queue for the back end. Uses pdq_pkg.
module pdq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [31:0]      req_dest_addr,
   input  logic [31:0]      req_dest_mask,
   input  logic             req_external,
   input  logic [15:0]      req_packet_handle,
   input  logic [7:0]       req_next_handler,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output pdq_pkg::cmd_type cmd
);
   import pdq_pkg::*;

   cmd_type q_ff [2];
   logic    rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   cmd_type in_cmd;
   logic push;

   // classify: external enqueue goes to the shared queue
   always_comb begin
      in_cmd.func    = req_func;
      in_cmd.addr    = (req_func == FUNC_ENQUEUE && req_external) ? 32'd0 : req_dest_addr;
      in_cmd.mask    = req_dest_mask;
      in_cmd.handle  = req_packet_handle;
      in_cmd.handler = req_next_handler;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (cmd_take) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, cmd_take};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_cmd;
   end
endmodule

// ===== sv/pdq_back.sv =====
// Back end: slot table, enqueue into per-slot FIFOs, ordered release drain.
// Uses pdq_pkg and pdq_ram for the entry store.
module pdq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             replace_oldest,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  pdq_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_status,
   output logic             rsp_route_request,
   output logic [15:0]      rsp_out_packet,
   output logic [7:0]       rsp_out_handler,
   output logic             rsp_last
);
   import pdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_WAIT, S_EMIT, S_NEXT
   } state_type;

   state_type   state_ff;
   logic [NUM_QUEUES-1:0] valid_ff;
   logic [31:0] addr_ff  [NUM_QUEUES];
   logic [RANK_W-1:0] rank_ff [NUM_QUEUES];
   logic [POS_W-1:0]  head_ff [NUM_QUEUES];
   logic [CNT_W-1:0]  count_ff [NUM_QUEUES];
   cmd_type     cur_ff;
   logic [RANK_W:0] rank_idx_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic        any_ff;
   logic        ovalid_ff;
   logic [1:0]  okind_ff, ostatus_ff;
   logic        oroute_ff, olast_ff;
   logic [15:0] opkt_ff;
   logic [7:0]  ohnd_ff;

   // entry store access
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] rd_data;

   pdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data({cur_ff.handle, cur_ff.handler}), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [ADDR_W-1:0] sidx(logic [SLOT_W-1:0] s, logic [POS_W-1:0] p);
      logic [ADDR_W+SLOT_W+POS_W:0] t;
      t = (ADDR_W+SLOT_W+POS_W+1)'(s) * (ADDR_W+SLOT_W+POS_W+1)'(ENTRIES_PER_QUEUE)
          + (ADDR_W+SLOT_W+POS_W+1)'(p);
      return t[ADDR_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pinc(logic [POS_W-1:0] p);
      logic [POS_W:0] t;
      t = {1'b0, p} + 1'b1;
      return (t == (POS_W+1)'(ENTRIES_PER_QUEUE)) ? '0 : t[POS_W-1:0];
   endfunction

   // slot lookup for the current command
   logic [SLOT_W-1:0] hit_s, free_s, rk_s;
   logic hit, has_free, rk_hit;
   logic [RANK_W:0] nvalid;
   always_comb begin
      hit = 1'b0; hit_s = '0; has_free = 1'b0; free_s = '0; nvalid = '0;
      rk_hit = 1'b0; rk_s = '0;
      for (int i = NUM_QUEUES-1; i >= 0; i--) begin
         if (valid_ff[i] && addr_ff[i] == cur_ff.addr) begin hit = 1'b1; hit_s = SLOT_W'(i); end
         if (!valid_ff[i]) begin has_free = 1'b1; free_s = SLOT_W'(i); end
         if (valid_ff[i] && {1'b0, rank_ff[i]} == rank_idx_ff) begin
            rk_hit = 1'b1; rk_s = SLOT_W'(i);
         end
      end
      for (int i = 0; i < NUM_QUEUES; i++) nvalid = nvalid + (RANK_W+1)'(valid_ff[i]);
   end

   logic [SLOT_W-1:0] es;
   logic full, do_push, do_pop;
   logic [POS_W:0] wpos_sum;
   logic [POS_W-1:0] wpos;
   always_comb begin
      es      = hit ? hit_s : free_s;
      full    = hit && count_ff[es] == CNT_W'(ENTRIES_PER_QUEUE);
      do_push = (state_ff == S_SCAN) && cur_ff.func == FUNC_ENQUEUE && (hit || has_free)
                && (!full || replace_oldest);
      do_pop  = do_push && full;
      wpos_sum = hit ? ({1'b0, head_ff[es]} + (POS_W+1)'(count_ff[es])) : '0;
      wpos = (wpos_sum >= (POS_W+1)'(ENTRIES_PER_QUEUE)) ?
             POS_W'(wpos_sum - (POS_W+1)'(ENTRIES_PER_QUEUE)) : wpos_sum[POS_W-1:0];
      wr_en   = do_push;
      wr_addr = sidx(es, wpos);
      rd_addr = sidx(slot_ff, head_ff[slot_ff]);
   end

   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;
   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;

   logic match;
   assign match = (addr_ff[rk_s] & cur_ff.mask) == (cur_ff.addr & cur_ff.mask);

   // no valid, matching, nonempty queue of a later rank remains
   logic last_after;
   always_comb begin
      last_after = 1'b1;
      for (int i = 0; i < NUM_QUEUES; i++)
         if (valid_ff[i] && SLOT_W'(i) != slot_ff && rank_ff[i] > rank_ff[slot_ff]
             && count_ff[i] != '0
             && (addr_ff[i] & cur_ff.mask) == (cur_ff.addr & cur_ff.mask))
            last_after = 1'b0;
   end

   // the entry being emitted is the last one of its queue
   logic drain_done;
   assign drain_done = (count_ff[slot_ff] == CNT_W'(1));

   // load the output register when a beat forms, drop it once taken
   logic emit, ovalid_in;
   always_comb begin
      case (state_ff)
         S_SCAN: emit = out_free && (cur_ff.func == FUNC_ENQUEUE
                        || (rank_idx_ff == (RANK_W+1)'(NUM_QUEUES) && !any_ff));
         S_EMIT: emit = out_free;
         default: emit = 1'b0;
      endcase
      ovalid_in = emit || (ovalid_ff && !rsp_ready);
   end

   // sequencer: enqueue in one step, release walks ranks and drains one entry a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         valid_ff  <= NUM_QUEUES'(1);
         for (int i = 0; i < NUM_QUEUES; i++) begin
            addr_ff[i] <= '0; rank_ff[i] <= '0; head_ff[i] <= '0; count_ff[i] <= '0;
         end
      end else begin
         ovalid_ff <= ovalid_in;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff      <= cmd;
                  rank_idx_ff <= '0;
                  any_ff      <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (cur_ff.func == FUNC_ENQUEUE) begin
                  if (out_free) begin
                     okind_ff <= KIND_STATUS; oroute_ff <= 1'b1;
                     opkt_ff <= '0; ohnd_ff <= '0; olast_ff <= 1'b1;
                     if (!hit && !has_free) ostatus_ff <= ST_NOSLOT;
                     else if (full) ostatus_ff <= replace_oldest ? ST_REPLACED : ST_FULL;
                     else ostatus_ff <= ST_QUEUED;
                     if (!hit && has_free) begin
                        valid_ff[es] <= 1'b1;
                        addr_ff[es]  <= cur_ff.addr;
                        rank_ff[es]  <= nvalid[RANK_W-1:0];
                        head_ff[es]  <= '0;
                     end
                     if (do_pop) head_ff[es] <= pinc(head_ff[es]);
                     else if (do_push) count_ff[es] <= hit ? count_ff[es] + 1'b1 : CNT_W'(1);
                     state_ff <= S_IDLE;
                  end
               end else if (rank_idx_ff == (RANK_W+1)'(NUM_QUEUES)) begin
                  if (!any_ff) begin
                     if (out_free) begin
                        okind_ff <= KIND_NOTHING; ostatus_ff <= ST_QUEUED;
                        oroute_ff <= 1'b0; opkt_ff <= '0; ohnd_ff <= '0; olast_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else if (rk_hit && match) begin
                  slot_ff  <= rk_s;
                  state_ff <= (count_ff[rk_s] != '0) ? S_READ : S_NEXT;
               end else begin
                  rank_idx_ff <= rank_idx_ff + 1'b1;
               end
            end
            S_READ: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_EMIT;
            S_EMIT: begin
               if (out_free) begin
                  okind_ff <= KIND_PACKET; ostatus_ff <= ST_QUEUED;
                  oroute_ff <= 1'b0; opkt_ff <= rd_data[23:8]; ohnd_ff <= rd_data[7:0];
                  any_ff <= 1'b1;
                  head_ff[slot_ff]  <= pinc(head_ff[slot_ff]);
                  count_ff[slot_ff] <= count_ff[slot_ff] - 1'b1;
                  // last beat: queue drained and no later matching rank holds entries
                  olast_ff <= drain_done && last_after;
                  state_ff <= drain_done ? S_NEXT : S_READ;
               end
            end
            S_NEXT: begin
               if (slot_ff != '0 && addr_ff[slot_ff] != '0) begin
                  for (int i = 0; i < NUM_QUEUES; i++)
                     if (valid_ff[i] && rank_ff[i] > rank_ff[slot_ff])
                        rank_ff[i] <= rank_ff[i] - 1'b1;
                  valid_ff[slot_ff] <= 1'b0; addr_ff[slot_ff] <= '0; rank_ff[slot_ff] <= '0;
                  head_ff[slot_ff] <= '0; count_ff[slot_ff] <= '0;
               end else begin
                  rank_idx_ff <= rank_idx_ff + 1'b1;
               end
               state_ff <= S_SCAN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_kind          = okind_ff;
   assign rsp_status        = ostatus_ff;
   assign rsp_route_request = oroute_ff;
   assign rsp_out_packet    = opkt_ff;
   assign rsp_out_handler   = ohnd_ff;
   assign rsp_last          = olast_ff;
endmodule

// ===== sv/per_destination_packet_queues.sv =====
// Top level of the per-destination packet queues: front queue, back end, CSR.
// Depends on pdq_pkg, pdq_front, pdq_back and pdq_ram.
//
// An enqueue passes through the request queue and a lookup step, and its status beat
// is then loaded into the output register. A release scans the eight creation ranks in
// order and then finishes; each matched queue also passes a free step (the shared queue
// is never freed), and each entry drained goes through a read, a wait and an emit state
// on the registered read port of the entry store. A two-entry request queue lets the
// input run ahead of the back end, and the output register holds the last beat while
// the back end reads the next entry; a new beat is loaded only once the last is taken.
module per_destination_packet_queues (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_dest_mask,
   input  logic        req_external,
   input  logic [15:0] req_packet_handle,
   input  logic [7:0]  req_next_handler,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_route_request,
   output logic [15:0] rsp_out_packet,
   output logic [7:0]  rsp_out_handler,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_wdata
);
   import pdq_pkg::*;

   logic    replace_ff;
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   // hold the replace-oldest register
   always_ff @(posedge clock) begin
      if (reset) replace_ff <= 1'b0;
      else if (csr_write) replace_ff <= csr_wdata;
   end

   pdq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_dest_addr,
      .req_dest_mask, .req_external, .req_packet_handle, .req_next_handler,
      .cmd_valid, .cmd_take, .cmd
   );

   pdq_back u_back (
      .clock, .reset, .replace_oldest(replace_ff), .cmd_valid, .cmd_take, .cmd,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_status, .rsp_route_request,
      .rsp_out_packet, .rsp_out_handler, .rsp_last
   );
endmodule

// ===== bench/pdq_checker.sv =====
// Checker for the per-destination packet queues: watches request and response beats,
// predicts the response stream from its own queue table and compares field by field.
// Depends on pdq_pkg.
`timescale 1ns / 1ps
module pdq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_dest_mask,
   input  logic        req_external,
   input  logic [15:0] req_packet_handle,
   input  logic [7:0]  req_next_handler,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_route_request,
   input  logic [15:0] rsp_out_packet,
   input  logic [7:0]  rsp_out_handler,
   input  logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_wdata,
   output int          fail_count,
   output int          pending_beats,
   output int          beats_seen
);
   import pdq_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic        route_request;
      logic [15:0] out_packet;
      logic [7:0]  out_handler;
      logic        last;
   } beat_type;

   beat_type    expected_beats[$];
   logic        replace_on;
   logic        q_valid[NUM_QUEUES];
   logic [31:0] q_addr[NUM_QUEUES];
   int          q_rank[NUM_QUEUES];
   int          q_head[NUM_QUEUES];
   int          q_count[NUM_QUEUES];
   logic [23:0] q_store[NUM_QUEUES][ENTRIES_PER_QUEUE];

   function automatic beat_type make_beat(logic [1:0] k, logic [1:0] st, logic rr,
                                          logic [15:0] p, logic [7:0] h);
      beat_type b;
      b.kind = k; b.status = st; b.route_request = rr;
      b.out_packet = p; b.out_handler = h; b.last = 1'b0;
      return b;
   endfunction

   task automatic push_word(int s, logic [23:0] w);
      q_store[s][(q_head[s] + q_count[s]) % ENTRIES_PER_QUEUE] = w;
      q_count[s]++;
   endtask

   task automatic predict_enqueue(logic [31:0] addr, logic [23:0] w);
      int s, nvalid;
      beat_type b;
      s = -1;
      nvalid = 0;
      for (int i = 0; i < NUM_QUEUES; i++)
         if (q_valid[i]) begin
            nvalid++;
            if (s < 0 && q_addr[i] == addr) s = i;
         end
      if (s < 0) begin
         for (int i = 0; i < NUM_QUEUES; i++)
            if (!q_valid[i] && s < 0) s = i;
         if (s >= 0) begin
            q_valid[s] = 1'b1; q_addr[s] = addr; q_rank[s] = nvalid & 7;
            q_head[s] = 0; q_count[s] = 0;
         end
      end
      if (s < 0)
         b = make_beat(KIND_STATUS, ST_NOSLOT, 1'b1, '0, '0);
      else if (q_count[s] >= ENTRIES_PER_QUEUE) begin
         if (replace_on) begin
            // drop the oldest entry, then append
            q_head[s] = (q_head[s] + 1) % ENTRIES_PER_QUEUE;
            q_count[s]--;
            push_word(s, w);
            b = make_beat(KIND_STATUS, ST_REPLACED, 1'b1, '0, '0);
         end else
            b = make_beat(KIND_STATUS, ST_FULL, 1'b1, '0, '0);
      end else begin
         push_word(s, w);
         b = make_beat(KIND_STATUS, ST_QUEUED, 1'b1, '0, '0);
      end
      b.last = 1'b1;
      expected_beats.push_back(b);
   endtask

   task automatic predict_release(logic [31:0] addr, logic [31:0] mask);
      int order[NUM_QUEUES];
      int s, n;
      logic [23:0] w;
      beat_type b;
      n = 0;
      for (int r = 0; r < NUM_QUEUES; r++) begin
         order[r] = -1;
         for (int i = 0; i < NUM_QUEUES; i++)
            if (order[r] < 0 && q_valid[i] && q_rank[i] == r) order[r] = i;
      end
      for (int r = 0; r < NUM_QUEUES; r++) begin
         s = order[r];
         if (s < 0) continue;
         if (!q_valid[s] || (q_addr[s] & mask) != (addr & mask)) continue;
         while (q_count[s] > 0) begin
            w = q_store[s][q_head[s]];
            q_head[s] = (q_head[s] + 1) % ENTRIES_PER_QUEUE;
            q_count[s]--;
            expected_beats.push_back(make_beat(KIND_PACKET, ST_QUEUED, 1'b0,
                                               w[23:8], w[7:0]));
            n++;
         end
         // free the queue, unless it is the shared one, and close the gap in creation ranks
         if (q_addr[s] != 0 && s != 0) begin
            for (int i = 0; i < NUM_QUEUES; i++)
               if (q_valid[i] && q_rank[i] > q_rank[s]) q_rank[i]--;
            q_valid[s] = 1'b0; q_addr[s] = '0; q_rank[s] = 0;
            q_head[s] = 0; q_count[s] = 0;
         end
      end
      if (n == 0) expected_beats.push_back(make_beat(KIND_NOTHING, ST_QUEUED, 1'b0, '0, '0));
      b = expected_beats.pop_back();
      b.last = 1'b1;
      expected_beats.push_back(b);
   endtask

   always @(posedge clock) begin
      beat_type got, want;
      if (reset) begin
         expected_beats.delete();
         replace_on = 1'b0;
         fail_count = 0;
         beats_seen = 0;
         pending_beats = 0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            q_valid[i] = (i == 0); q_addr[i] = '0; q_rank[i] = 0;
            q_head[i] = 0; q_count[i] = 0;
         end
      end else begin
         // compare the response beat first: it was formed before this request
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            got.kind = rsp_kind; got.status = rsp_status;
            got.route_request = rsp_route_request; got.out_packet = rsp_out_packet;
            got.out_handler = rsp_out_handler; got.last = rsp_last;
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response beat %p", got);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (csr_write) replace_on = csr_wdata;
         if (req_valid && req_ready) begin
            if (req_func == FUNC_ENQUEUE)
               predict_enqueue(req_external ? 32'd0 : req_dest_addr,
                               {req_packet_handle, req_next_handler});
            else
               predict_release(req_dest_addr, req_dest_mask);
         end
         pending_beats = expected_beats.size();
      end
   end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the per-destination packet queues: drives requests, the replace
// register and response back-pressure, gives the verdict. Needs the top and pdq_checker.
`timescale 1ns / 1ps
module tb_top;
   import pdq_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_ready, req_func, req_external;
   logic [31:0] req_dest_addr, req_dest_mask;
   logic [15:0] req_packet_handle;
   logic [7:0]  req_next_handler;
   logic        rsp_valid, rsp_ready, rsp_route_request, rsp_last;
   logic [1:0]  rsp_kind, rsp_status;
   logic [15:0] rsp_out_packet;
   logic [7:0]  rsp_out_handler;
   logic        csr_write, csr_wdata;
   int          fail_count, pending_beats, beats_seen;
   int          send_idle_pct, recv_idle_pct, hold_off_cycles, cycle_count;
   int          items_sent;
   logic        hold_off_start, hold_off_done;
   logic [31:0] dest_pool[6];

   per_destination_packet_queues DUT (.*);
   pdq_checker checker_i (.*);

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   // receiver: random stall, or one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         hold_off_cycles <= 0;
         hold_off_done   <= 1'b0;
         rsp_ready       <= 1'b0;
      end else if (hold_off_start && !hold_off_done) begin
         hold_off_done   <= 1'b1;
         hold_off_cycles <= 300;
         rsp_ready       <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // end the run on a hung block
   always @(posedge clock) begin
      if (reset) cycle_count <= 0;
      else cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_beat(logic f, logic [31:0] a, logic [31:0] m, logic x,
                            logic [15:0] h, logic [7:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_func <= f; req_dest_addr <= a; req_dest_mask <= m;
      req_external <= x; req_packet_handle <= h; req_next_handler <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_beats != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_replace(logic v);
      drain_and_settle();
      csr_write <= 1'b1; csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly enqueues to a few destinations, with releases that match some of them
   task automatic random_beat();
      logic [31:0] a, m;
      int pick;
      pick = $urandom_range(99);
      a = ($urandom_range(9) == 0) ? $urandom : dest_pool[$urandom_range(5)];
      if (pick < 78)
         send_beat(FUNC_ENQUEUE, a, $urandom, $urandom_range(7) == 0,
                   16'($urandom), 8'($urandom));
      else begin
         case ($urandom_range(3))
            0: m = 32'hFFFF_FFFF;
            1: m = 32'hFFFF_FF00;
            2: m = 32'h0;
            default: m = $urandom;
         endcase
         send_beat(FUNC_RELEASE, a, m, 1'($urandom_range(1)), 16'($urandom),
                   8'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_func = FUNC_ENQUEUE; req_dest_addr = '0;
      req_dest_mask = '0; req_external = 1'b0; req_packet_handle = '0;
      req_next_handler = '0; csr_write = 1'b0; csr_wdata = 1'b0;
      send_idle_pct = 9; recv_idle_pct = 78; hold_off_start = 1'b0;
      items_sent = 0;
      dest_pool = '{32'h0A00_0001, 32'h0A00_0002, 32'hC0A8_0105, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'h0A00_0003};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill one queue past full, shared queue, extremes
      write_replace(1'b0);
      for (int i = 0; i < 9; i++)
         send_beat(FUNC_ENQUEUE, 32'h0A00_0001, '0, 1'b0, 16'(16'hFFFF - i),
                   8'(8'hFF - i));
      send_beat(FUNC_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, 8'h00);
      send_beat(FUNC_ENQUEUE, 32'h0000_0000, '0, 1'b0, 16'h1234, 8'h56);
      // use up every slot, then one more destination gets no slot
      for (int i = 2; i < 9; i++)
         send_beat(FUNC_ENQUEUE, 32'h0B00_0000 + i, '0, 1'b0, 16'(16'h0100 + i),
                   8'(8'h10 + i));
      send_beat(FUNC_RELEASE, 32'h0C00_0000, 32'hFFFF_FFFF, 1'b0, '0, '0);
      send_beat(FUNC_RELEASE, 32'h0A00_0001, 32'hFFFF_FFFF, 1'b0, '0, '0);
      write_replace(1'b1);
      for (int i = 0; i < 9; i++)
         send_beat(FUNC_ENQUEUE, 32'h0000_0000, '0, 1'b1, 16'(16'h2000 + i),
                   8'(8'h20 + i));
      send_beat(FUNC_RELEASE, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'hFFFF, 8'hFF);
      send_beat(FUNC_RELEASE, 32'h0, 32'h0, 1'b0, '0, '0);

      // long hold-off while requests keep coming
      hold_off_start <= 1'b1;
      for (int i = 0; i < 12; i++) random_beat();

      for (int phase = 0; phase < 3; phase++) begin
         write_replace(phase == 1);
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
         for (int i = 0; i < 41; i++) random_beat();
         send_beat(FUNC_RELEASE, '0, '0, 1'b0, '0, '0);
      end

      drain_and_settle();
      $display("Sent %0d requests and checked %0d response beats,", items_sent, beats_seen);
      $display("covering full, replaced, no-slot and masked releases.");
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
